// ===== src/ntg_pkg.sv =====
// ----------------------------------------------------------------------------
// ntg_pkg
// Shared types, constants and helpers for the twiddle table generator.
// ----------------------------------------------------------------------------
package ntg_pkg;

  localparam int MAX_LOG_LEN = 12;
  localparam int COUNT_W     = MAX_LOG_LEN;
  localparam int WORD_W      = 32;
  localparam int DWORD_W     = 2 * WORD_W;
  localparam int LOG_W       = 4;
  localparam int POS_W       = 12;

  localparam logic [WORD_W-1:0] MODULUS_RST = 32'd268369921;
  localparam logic [WORD_W-1:0] ROOT_RST    = 32'd1;
  localparam logic [LOG_W-1:0]  LOG_LEN_RST = 4'd11;

  typedef enum logic [1:0] {
    REG_MODULUS = 2'd0,
    REG_ROOT    = 2'd1,
    REG_LOG_LEN = 2'd2,
    REG_HALVE   = 2'd3
  } cfg_reg_e;

  function automatic logic [COUNT_W-1:0] rev_bits(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    for (int k = 0; k < COUNT_W; k++) begin
      r[k] = v[COUNT_W-1-k];
    end
    return r;
  endfunction

endpackage

// ===== src/ntg_if.sv =====
// ----------------------------------------------------------------------------
// ntg_if
// Valid/ready stream channels of the twiddle table generator.
// ----------------------------------------------------------------------------
interface ntg_in_if;
  import ntg_pkg::*;

  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface ntg_out_if;
  import ntg_pkg::*;

  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    position;
  logic [WORD_W-1:0]   twiddle;
  logic [WORD_W-1:0]   scaled_twiddle;
  logic                last;

  modport source (output valid, output position, output twiddle, output scaled_twiddle,
                  output last, input ready);
  modport sink   (input valid, input position, input twiddle, input scaled_twiddle,
                  input last, output ready);
endinterface

// ===== src/ntt_twiddle_table_generator_top.sv =====
// ----------------------------------------------------------------------------
// ntt_twiddle_table_generator_top
// Walks an NTT twiddle table one entry per input word: power of the root,
// optional halving, Shoup-scaled word and bit-reversed position.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                      handshake
//  in_i     in   restart                                      valid/ready
//  out_o    out  position, twiddle, scaled_twiddle, last      valid/ready
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i              write strobe
//
//  a word on the final entry of the table is accepted, its power reduced, its
//  scaled word formed and the entry emitted; any other word then also has the
//  root reduced, one multiply and the product reduced, all on the shared one-bit
//  restoring divide step: 32 steps for the power, 32 for the scaled word, 32 for
//  the root and 64 for the product; in_i.ready is high only while the sequencer is idle
//  a stalled out_o holds the sequencer in its emit state
//  reset is asynchronous and active low; registers return to their reset values
// ----------------------------------------------------------------------------
module ntt_twiddle_table_generator_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  ntg_pkg::cfg_reg_e cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  ntg_in_if.sink            in_i,
  ntg_out_if.source         out_o
);
  import ntg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDP,
    S_SCALE,
    S_EMIT,
    S_REDR,
    S_MUL,
    S_REDM
  } state_e;

  state_e              state_q, state_d;
  logic [WORD_W-1:0]   mod_q, mod_d;
  logic [WORD_W-1:0]   root_q, root_d;
  logic [LOG_W-1:0]    log_len_q, log_len_d;
  logic                halve_q, halve_d;

  logic [WORD_W-1:0]   power_q, power_d;
  logic [COUNT_W-1:0]  count_q, count_d;

  logic [WORD_W-1:0]   rem_q, rem_d;
  logic [DWORD_W-1:0]  div_q, div_d;
  logic [5:0]          step_q, step_d;
  logic [WORD_W-1:0]   pr_q, pr_d;
  logic [WORD_W-1:0]   rr_q, rr_d;
  logic [WORD_W-1:0]   val_q, val_d;
  logic [WORD_W-1:0]   scl_q, scl_d;

  logic                out_valid_q, out_valid_d;
  logic [POS_W-1:0]    out_pos_q, out_pos_d;
  logic [WORD_W-1:0]   out_tw_q, out_tw_d;
  logic [WORD_W-1:0]   out_scl_q, out_scl_d;
  logic                out_last_q, out_last_d;

  // shared divide step
  logic [WORD_W:0]     rem_sh;
  logic [WORD_W:0]     rem_sub;
  logic                ge;
  logic [WORD_W-1:0]   rem_new;
  logic [DWORD_W-1:0]  div_new;
  logic [WORD_W-1:0]   mod_res;
  logic                mod_zero;

  logic [WORD_W:0]     half_sum;
  logic [WORD_W-1:0]   halved;

  logic [LOG_W-1:0]    eff_log;
  logic [COUNT_W-1:0]  last_index;
  logic                is_last;
  logic [COUNT_W-1:0]  rev_v;
  logic [POS_W-1:0]    position;

  assign mod_zero = (mod_q == '0);
  assign rem_sh   = {rem_q, div_q[DWORD_W-1]};
  assign ge       = (rem_sh >= {1'b0, mod_q});
  assign rem_sub  = rem_sh - {1'b0, mod_q};
  assign rem_new  = ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
  assign div_new  = {div_q[DWORD_W-2:0], ge};
  assign mod_res  = mod_zero ? '0 : rem_new;

  // halving mod q: an odd value takes q added first
  assign half_sum = {1'b0, mod_res} + {1'b0, mod_q};
  always_comb begin
    if (!halve_q) begin
      halved = mod_res;
    end else if (mod_res[0]) begin
      halved = half_sum[WORD_W:1];
    end else begin
      halved = {1'b0, mod_res[WORD_W-1:1]};
    end
  end

  assign eff_log    = (int'(log_len_q) > MAX_LOG_LEN) ? LOG_W'(MAX_LOG_LEN) : log_len_q;
  assign last_index = COUNT_W'(((COUNT_W+1)'(1) << eff_log) - (COUNT_W+1)'(1));
  assign is_last    = (count_q >= last_index);
  assign rev_v      = rev_bits(count_q & last_index) >> (COUNT_W - int'(eff_log));
  assign position   = POS_W'(rev_v);

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.position       = out_pos_q;
  assign out_o.twiddle        = out_tw_q;
  assign out_o.scaled_twiddle = out_scl_q;
  assign out_o.last           = out_last_q;

  always_comb begin
    state_d     = state_q;
    mod_d       = mod_q;
    root_d      = root_q;
    log_len_d   = log_len_q;
    halve_d     = halve_q;
    power_d     = power_q;
    count_d     = count_q;
    rem_d       = rem_q;
    div_d       = div_q;
    step_d      = step_q;
    pr_d        = pr_q;
    rr_d        = rr_q;
    val_d       = val_q;
    scl_d       = scl_q;
    out_valid_d = out_valid_q;
    out_pos_d   = out_pos_q;
    out_tw_d    = out_tw_q;
    out_scl_d   = out_scl_q;
    out_last_d  = out_last_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODULUS: mod_d     = cfg_data_i;
        REG_ROOT:    root_d    = cfg_data_i;
        REG_LOG_LEN: log_len_d = cfg_data_i[LOG_W-1:0];
        REG_HALVE:   halve_d   = cfg_data_i[0];
        default:     ;
      endcase
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          rem_d  = '0;
          step_d = 6'(WORD_W - 1);
          if (in_i.restart) begin
            power_d = WORD_W'(1);
            count_d = '0;
            div_d   = {WORD_W'(1), {WORD_W{1'b0}}};
          end else begin
            div_d   = {power_q, {WORD_W{1'b0}}};
          end
          state_d = S_REDP;
        end
      end
      S_REDP: begin
        rem_d  = rem_new;
        div_d  = div_new;
        step_d = step_q - 6'd1;
        if (step_q == '0) begin
          pr_d    = mod_res;
          val_d   = halved;
          // halved value stays below q, so it seeds the remainder directly
          rem_d   = halved;
          div_d   = '0;
          step_d  = 6'(WORD_W - 1);
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        rem_d  = rem_new;
        div_d  = div_new;
        step_d = step_q - 6'd1;
        if (step_q == '0) begin
          scl_d   = mod_zero ? '0 : div_new[WORD_W-1:0];
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_pos_d   = position;
          out_tw_d    = val_q;
          out_scl_d   = scl_q;
          out_last_d  = is_last;
          if (is_last) begin
            power_d = WORD_W'(1);
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            rem_d   = '0;
            div_d   = {root_q, {WORD_W{1'b0}}};
            step_d  = 6'(WORD_W - 1);
            state_d = S_REDR;
          end
        end
      end
      S_REDR: begin
        rem_d  = rem_new;
        div_d  = div_new;
        step_d = step_q - 6'd1;
        if (step_q == '0) begin
          rr_d    = mod_res;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        div_d   = DWORD_W'(pr_q) * DWORD_W'(rr_q);
        rem_d   = '0;
        step_d  = 6'(DWORD_W - 1);
        state_d = S_REDM;
      end
      S_REDM: begin
        rem_d  = rem_new;
        div_d  = div_new;
        step_d = step_q - 6'd1;
        if (step_q == '0) begin
          power_d = mod_res;
          count_d = count_q + COUNT_W'(1);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mod_q       <= MODULUS_RST;
      root_q      <= ROOT_RST;
      log_len_q   <= LOG_LEN_RST;
      halve_q     <= 1'b0;
      power_q     <= WORD_W'(1);
      count_q     <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      step_q      <= '0;
      pr_q        <= '0;
      rr_q        <= '0;
      val_q       <= '0;
      scl_q       <= '0;
      out_valid_q <= 1'b0;
      out_pos_q   <= '0;
      out_tw_q    <= '0;
      out_scl_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      mod_q       <= mod_d;
      root_q      <= root_d;
      log_len_q   <= log_len_d;
      halve_q     <= halve_d;
      power_q     <= power_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      div_q       <= div_d;
      step_q      <= step_d;
      pr_q        <= pr_d;
      rr_q        <= rr_d;
      val_q       <= val_d;
      scl_q       <= scl_d;
      out_valid_q <= out_valid_d;
      out_pos_q   <= out_pos_d;
      out_tw_q    <= out_tw_d;
      out_scl_q   <= out_scl_d;
      out_last_q  <= out_last_d;
    end
  end

  // partial remainder stays below q throughout every divide
  a_rem_below_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_REDP || state_q == S_SCALE || state_q == S_REDR || state_q == S_REDM)
     && !mod_zero) |-> (rem_q < mod_q))
    else $error("divide remainder not below modulus");

  // a freshly emitted twiddle is reduced
  a_twiddle_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (mod_zero || out_tw_q < mod_q))
    else $error("twiddle not below modulus");

  // leaving emit straight for idle only happens on the final entry, which rewinds the walk
  a_wrap_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && $past(state_q) == S_EMIT) |->
      (count_q == '0 && power_q == WORD_W'(1) && out_last_q))
    else $error("walk not rewound after final entry");

  // a scaled word is only taken once the divider has finished its steps
  a_scale_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && $past(state_q) == S_SCALE) |-> ($past(step_q) == '0))
    else $error("scale divide cut short");

endmodule

// ===== test/ntt_twiddle_table_generator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_twiddle_table_generator_top_tb
// Self-checking bench for the twiddle table generator: a directed table of
// corner settings, then randomised register settings and restart words, with
// random gaps on both channels. Every table entry is scored against an in-bench
// model of the power walk, halving, Shoup scaling and bit reversal, or against a pinned value in directed rows.
// ----------------------------------------------------------------------------
module ntt_twiddle_table_generator_top_tb;
  import ntg_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RST_CYCLES  = 5;
  localparam int WORD_TARGET = 1750;
  localparam int CYCLE_LIMIT = 2_500_000;
  localparam int TAIL_CYCLES = 200;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] tw;
    logic [WORD_W-1:0] sc;
    logic              lst;
  } tw_entry_t;

  typedef struct packed {
    logic              cfg;
    logic [WORD_W-1:0] q;
    logic [WORD_W-1:0] g;
    logic [LOG_W-1:0]  lg;
    logic              hv;
    logic              rs;
    logic              pin;
    tw_entry_t         want;
  } stim_row_t;

  localparam tw_entry_t NO_PIN = '0;

  // cfg rows reprogram all four registers before their word goes in
  localparam stim_row_t DIR_ROWS [25] = '{
    // reset settings, unit root
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b1, '{12'd0, 32'd1, 32'd16, 1'b0}},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b1, '{12'd1024, 32'd1, 32'd16, 1'b0}},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b1, 1'b1, '{12'd0, 32'd1, 32'd16, 1'b0}},
    // short table, full walk and wrap
    '{1'b1, 32'd17, 32'd3, 4'd2, 1'b0, 1'b1, 1'b0, NO_PIN},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b0, NO_PIN},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b0, NO_PIN},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b0, NO_PIN},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b0, NO_PIN},
    // single-entry table, halved
    '{1'b1, 32'd17, 32'd3, 4'd0, 1'b1, 1'b1, 1'b1, '{12'd0, 32'd9, 32'd2273806215, 1'b1}},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b1, '{12'd0, 32'd9, 32'd2273806215, 1'b1}},
    // oversized log length, root above modulus
    '{1'b1, 32'd4294967291, 32'd4294967295, 4'd15, 1'b0, 1'b0, 1'b1,
      '{12'd0, 32'd1, 32'd1, 1'b0}},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b0, NO_PIN},
    // zero modulus
    '{1'b1, 32'd0, 32'd5, 4'd3, 1'b1, 1'b1, 1'b1, '{12'd0, 32'd0, 32'd0, 1'b0}},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b1, '{12'd4, 32'd0, 32'd0, 1'b0}},
    // unit modulus
    '{1'b1, 32'd1, 32'd0, 4'd1, 1'b0, 1'b1, 1'b1, '{12'd0, 32'd0, 32'd0, 1'b0}},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b1, '{12'd1, 32'd0, 32'd0, 1'b1}},
    // even modulus with halving
    '{1'b1, 32'd10, 32'd7, 4'd2, 1'b1, 1'b1, 1'b1, '{12'd0, 32'd5, 32'd2147483648, 1'b0}},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b0, NO_PIN},
    // long table, then shrink table and modulus mid-walk
    '{1'b1, 32'd4294967291, 32'd123456789, 4'd12, 1'b0, 1'b1, 1'b0, NO_PIN},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b0, NO_PIN},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b0, NO_PIN},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b0, NO_PIN},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b0, NO_PIN},
    '{1'b1, 32'd13, 32'd2, 4'd2, 1'b0, 1'b0, 1'b0, NO_PIN},
    '{1'b0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0, 1'b1, '{12'd0, 32'd1, 32'd330382099, 1'b0}}
  };

  localparam logic [WORD_W-1:0] PRIMES [10] = '{
    32'd17, 32'd257, 32'd3329, 32'd7681, 32'd12289, 32'd65537, 32'd786433,
    32'd268369921, 32'd2013265921, 32'd4294967291
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  cfg_reg_e          cfg_idx_i;
  logic [WORD_W-1:0] cfg_data_i;
  logic              sink_rdy = 1'b0;
  logic              pin_en;
  tw_entry_t         pin_want;

  ntg_in_if  in_if ();
  ntg_out_if out_if ();

  assign out_if.ready = sink_rdy;

  ntt_twiddle_table_generator_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // model registers and walk state
  logic [WORD_W-1:0]  mdl_q, mdl_g, pw_state;
  logic [LOG_W-1:0]   mdl_log;
  logic               mdl_halve;
  logic [COUNT_W-1:0] cnt_state;

  tw_entry_t tw_expect [$];
  bit        calm;
  int        err_cnt, n_sent, n_accepted, n_results, n_last, n_halved, n_restart;
  int        n_settings, stall_left, cyc_cnt;

  function automatic tw_entry_t predict_entry(input logic rs);
    int unsigned       eff, last_idx, idx;
    logic [63:0]       v, quot;
    tw_entry_t         e;
    if (rs) begin
      pw_state  = 32'd1;
      cnt_state = '0;
    end
    eff      = (mdl_log > MAX_LOG_LEN) ? MAX_LOG_LEN : mdl_log;
    last_idx = (32'd1 << eff) - 32'd1;
    v = (mdl_q == 0) ? 64'd0 : 64'(pw_state) % 64'(mdl_q);
    if (mdl_halve) begin
      v = v[0] ? (v + 64'(mdl_q)) >> 1 : v >> 1;
    end
    quot  = (mdl_q == 0) ? 64'd0 : (v << 32) / 64'(mdl_q);
    e.tw  = v[31:0];
    e.sc  = quot[31:0];
    e.lst = (cnt_state >= last_idx);
    idx   = cnt_state & last_idx;
    e.pos = '0;
    for (int k = 0; k < eff; k++) begin
      e.pos = {e.pos[POS_W-2:0], idx[0]};
      idx   = idx >> 1;
    end
    if (e.lst) begin
      pw_state  = 32'd1;
      cnt_state = '0;
    end else begin
      pw_state = (mdl_q == 0) ? 32'd0 :
        32'(((64'(pw_state) % 64'(mdl_q)) * (64'(mdl_g) % 64'(mdl_q))) % 64'(mdl_q));
      cnt_state = cnt_state + 1'b1;
    end
    return e;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(4, 1);
    return $urandom_range(64, 12);
  endfunction

  function automatic int pick_stall();
    if ($urandom_range(99) < 85) return $urandom_range(4, 1);
    return $urandom_range(64, 12);
  endfunction

  // sink side: random back-pressure, no new stalls start in calm phases
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sink_rdy <= 1'b0;
    end else begin
      if (stall_left == 0 && !calm && $urandom_range(31) == 0) stall_left = pick_stall();
      if (stall_left > 0) begin
        sink_rdy <= 1'b0;
        stall_left--;
      end else begin
        sink_rdy <= 1'b1;
      end
    end
  end

  // scoreboard: register writes, accepted words and returned entries
  always @(posedge clk_i or negedge rst_ni) begin : score
    tw_entry_t got, want;
    if (!rst_ni) begin
      mdl_q     = MODULUS_RST;
      mdl_g     = ROOT_RST;
      mdl_log   = LOG_LEN_RST;
      mdl_halve = 1'b0;
      pw_state  = 32'd1;
      cnt_state = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODULUS: mdl_q     = cfg_data_i;
          REG_ROOT:    mdl_g     = cfg_data_i;
          REG_LOG_LEN: mdl_log   = cfg_data_i[LOG_W-1:0];
          REG_HALVE:   mdl_halve = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.position, out_if.twiddle, out_if.scaled_twiddle, out_if.last};
        n_results++;
        if (got.lst) n_last++;
        if (tw_expect.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("unexpected entry: pos %0d twiddle %0d scaled %0d last %0b",
                     got.pos, got.tw, got.sc, got.lst);
        end else begin
          want = tw_expect.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display({"entry %0d wrong (exp/act): pos %0d/%0d twiddle %0d/%0d",
                        " scaled %0d/%0d last %0b/%0b"},
                       n_results, want.pos, got.pos, want.tw, got.tw, want.sc, got.sc,
                       want.lst, got.lst);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        n_accepted++;
        if (in_if.restart) n_restart++;
        if (mdl_halve) n_halved++;
        want = predict_entry(in_if.restart);
        if (pin_en) want = pin_want;
        tw_expect.push_back(want);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d entries outstanding", cyc_cnt, tw_expect.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_word(input logic rs, input logic pin, input tw_entry_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.restart <= rs;
    pin_en        <= pin;
    pin_want      <= want;
    do @(posedge clk_i); while (!in_if.ready);
    n_sent++;
  endtask

  // hold the sender until every entry is back and the sequencer is idle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tw_expect.size() != 0 || !in_if.ready) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [WORD_W-1:0] q, input logic [WORD_W-1:0] g,
                              input logic [LOG_W-1:0] lg, input logic hv);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_MODULUS;
    cfg_data_i <= q;
    @(posedge clk_i);
    cfg_idx_i  <= REG_ROOT;
    cfg_data_i <= g;
    @(posedge clk_i);
    cfg_idx_i  <= REG_LOG_LEN;
    cfg_data_i <= WORD_W'(lg);
    @(posedge clk_i);
    cfg_idx_i  <= REG_HALVE;
    cfg_data_i <= WORD_W'(hv);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    n_settings++;
  endtask

  initial begin
    logic [WORD_W-1:0] q, g;
    logic [LOG_W-1:0]  lg;
    int                r, n;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_MODULUS;
    cfg_data_i    <= '0;
    in_if.valid   <= 1'b0;
    in_if.restart <= 1'b0;
    pin_en        <= 1'b0;
    pin_want      <= NO_PIN;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].cfg) begin
        wait_idle();
        program_regs(DIR_ROWS[i].q, DIR_ROWS[i].g, DIR_ROWS[i].lg, DIR_ROWS[i].hv);
      end
      send_word(DIR_ROWS[i].rs, DIR_ROWS[i].pin, DIR_ROWS[i].want);
    end

    while (n_sent < WORD_TARGET) begin
      wait_idle();
      calm = ($urandom_range(3) == 0);
      r = $urandom_range(19);
      if (r < 10)       q = PRIMES[r];
      else if (r < 13)  q = $urandom() | 32'd1;
      else if (r == 13) q = 32'd0;
      else if (r == 14) q = 32'd1;
      else if (r == 15) q = 32'd3;
      else if (r == 16) q = 32'hFFFF_FFFF;
      else if (r == 17) q = $urandom() & ~32'd1;
      else              q = $urandom_range(1000, 3) | 32'd1;
      r = $urandom_range(19);
      if (r < 14)       g = (q > 1) ? $urandom_range(q - 1) : $urandom();
      else if (r == 14) g = 32'd0;
      else if (r == 15) g = 32'd1;
      else if (r == 16) g = q - 1;
      else if (r == 17) g = 32'hFFFF_FFFF;
      else              g = $urandom();
      // mostly short tables so the final entry and wrap come round often
      r = $urandom_range(19);
      if (r < 10)       lg = LOG_W'($urandom_range(4));
      else if (r < 16)  lg = LOG_W'($urandom_range(8, 5));
      else if (r < 18)  lg = LOG_W'($urandom_range(11, 9));
      else if (r == 18) lg = 4'd12;
      else              lg = LOG_W'($urandom_range(15, 13));
      program_regs(q, g, lg, 1'($urandom_range(1)));
      n = $urandom_range(60, 10);
      repeat (n) begin
        if ($urandom_range(79) == 0) wait_idle();
        send_word($urandom_range(15) == 0, 1'b0, NO_PIN);
      end
    end

    in_if.valid <= 1'b0;
    while (tw_expect.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    err_cnt += tw_expect.size();

    $display("%0d words over %0d register settings, %0d restarts, %0d halved",
             n_accepted, n_settings, n_restart, n_halved);
    $display("%0d table entries checked, %0d final entries, %0d mismatches",
             n_results, n_last, err_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
